[sv/c_like_token_scanner_assert.svh]
// Assertion macros used by the scanner queue module.
// Each macro expects clk and rst_n in scope.
`ifndef C_LIKE_TOKEN_SCANNER_ASSERT_SVH
`define C_LIKE_TOKEN_SCANNER_ASSERT_SVH
`ifndef SYNTH
`define CTS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("scanner assertion failed");
`define CTS_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("scanner assertion failed");
`else
`define CTS_ASSERT(lbl, prop)
`define CTS_NEVER(lbl, cond)
`endif
`endif

[sv/cts_pkg.sv]
package cts_pkg;

  localparam int LINE_BITS   = 20;
  localparam int COLUMN_BITS = 16;
  localparam int OFFSET_BITS = 24;
  localparam int LENGTH_BITS = 16;
  localparam int MAX_RES     = 3;

  typedef logic [5:0] kind_t;
  typedef logic [2:0] err_t;

  localparam kind_t K_IDENT    = 6'd0;
  localparam kind_t K_NUMBER   = 6'd1;
  localparam kind_t K_CHAR     = 6'd2;
  localparam kind_t K_STRING   = 6'd3;
  localparam kind_t K_INVALID  = 6'd4;
  localparam kind_t K_PLUS     = 6'd5;
  localparam kind_t K_INC      = 6'd6;
  localparam kind_t K_PLUS_EQ  = 6'd7;
  localparam kind_t K_MINUS    = 6'd8;
  localparam kind_t K_DEC      = 6'd9;
  localparam kind_t K_MINUS_EQ = 6'd10;
  localparam kind_t K_ARROW    = 6'd11;
  localparam kind_t K_STAR     = 6'd12;
  localparam kind_t K_STAR_EQ  = 6'd13;
  localparam kind_t K_SLASH    = 6'd14;
  localparam kind_t K_SLASH_EQ = 6'd15;
  localparam kind_t K_PCT      = 6'd16;
  localparam kind_t K_PCT_EQ   = 6'd17;
  localparam kind_t K_ASSIGN   = 6'd18;
  localparam kind_t K_EQ       = 6'd19;
  localparam kind_t K_BANG     = 6'd20;
  localparam kind_t K_NE       = 6'd21;
  localparam kind_t K_GT       = 6'd22;
  localparam kind_t K_GE       = 6'd23;
  localparam kind_t K_SHR      = 6'd24;
  localparam kind_t K_SHR_EQ   = 6'd25;
  localparam kind_t K_LT       = 6'd26;
  localparam kind_t K_LE       = 6'd27;
  localparam kind_t K_SHL      = 6'd28;
  localparam kind_t K_SHL_EQ   = 6'd29;
  localparam kind_t K_AMP      = 6'd30;
  localparam kind_t K_AND      = 6'd31;
  localparam kind_t K_AMP_EQ   = 6'd32;
  localparam kind_t K_PIPE     = 6'd33;
  localparam kind_t K_OR       = 6'd34;
  localparam kind_t K_PIPE_EQ  = 6'd35;
  localparam kind_t K_CARET    = 6'd36;
  localparam kind_t K_CARET_EQ = 6'd37;
  localparam kind_t K_TILDE    = 6'd38;
  localparam kind_t K_AT       = 6'd39;
  localparam kind_t K_DOT      = 6'd40;
  localparam kind_t K_QUEST    = 6'd41;
  localparam kind_t K_SCOPE    = 6'd42;
  localparam kind_t K_COLON    = 6'd43;
  localparam kind_t K_SEMI     = 6'd44;
  localparam kind_t K_COMMA    = 6'd45;
  localparam kind_t K_LBRACK   = 6'd46;
  localparam kind_t K_RBRACK   = 6'd47;
  localparam kind_t K_LPAREN   = 6'd48;
  localparam kind_t K_RPAREN   = 6'd49;
  localparam kind_t K_LBRACE   = 6'd50;
  localparam kind_t K_RBRACE   = 6'd51;
  localparam kind_t K_END      = 6'd52;
  localparam kind_t K_DIAG     = 6'd53;

  localparam err_t E_NONE       = 3'd0;
  localparam err_t E_OPEN_CMT   = 3'd1;
  localparam err_t E_MULTI_CHAR = 3'd2;
  localparam err_t E_OPEN_CHAR  = 3'd3;
  localparam err_t E_OPEN_STR   = 3'd4;
  localparam err_t E_BAD_CHAR   = 3'd5;

  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_source;
  } in_item_t;

  typedef struct packed {
    kind_t                  token_kind;
    logic [LINE_BITS-1:0]   tok_line;
    logic [COLUMN_BITS-1:0] tok_column;
    logic [OFFSET_BITS-1:0] start_offset;
    logic [LENGTH_BITS-1:0] token_length;
    err_t                   error_code;
    logic                   last_item;
  } out_item_t;

  // All results caused by one input beat, oldest in slot 0.
  typedef struct packed {
    logic [1:0]                 cnt;
    out_item_t [MAX_RES-1:0]    res;
  } bundle_t;

endpackage

[sv/c_like_token_scanner.sv]
// Channel | Direction | Handshake        | Beat payload
// in      | input     | in_push/in_full  | in_item   (char_code, end_of_source)
// out     | output    | out_pop/out_empty| out_item  (token fields, last_item)
//
// One byte is accepted per cycle while the result queue has room.
// A byte that makes k results delivers them on out_item one at a time, in order.
// A result passes through the queue and the output register before it shows on out_item.
// Reset is synchronous on rst_n; the scanner returns to line 1, column 1.
// A stalled output fills the QUEUE_DEPTH-entry queue, then raises in_full.
module c_like_token_scanner import cts_pkg::*; #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_push,
  output logic      in_full,
  input  in_item_t  in_item,
  output logic      out_empty,
  input  logic      out_pop,
  output out_item_t out_item
);

  logic    accept, b_valid, q_empty, q_pop;
  bundle_t b_data, q_head;

  assign accept = in_push && !in_full;

  cts_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .in_item      (in_item),
    .bundle_valid (b_valid),
    .bundle       (b_data)
  );

  cts_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (b_valid),
    .wr_data (b_data),
    .rd_en   (q_pop),
    .rd_data (q_head),
    .full    (in_full),
    .empty   (q_empty)
  );

  cts_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (q_head),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_item  (out_item)
  );

endmodule

[sv/cts_front.sv]
module cts_front import cts_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     accept,
  input  in_item_t in_item,
  output logic     bundle_valid,
  output bundle_t  bundle
);

  typedef enum logic [4:0] {
    M_IDLE, M_IDENT, M_NUM_INT, M_NUM_DOT, M_NUM_FRAC, M_CHAR_OPEN, M_CHAR_ONE,
    M_CHAR_MULTI, M_STR, M_LINE_CMT, M_BLOCK, M_BLOCK_STAR, M_PLUS, M_MINUS,
    M_STAR, M_SLASH, M_PERCENT, M_EQUAL, M_BANG, M_GT, M_GTGT, M_LT, M_LTLT,
    M_AMP, M_PIPE, M_CARET, M_COLON
  } mode_t;

  typedef struct packed {
    logic  space;
    mode_t mode;
    logic  single;
    kind_t kind;
  } cls_t;

  typedef struct packed {
    logic  hit;
    kind_t kind;
  } pair_t;

  localparam logic [LINE_BITS-1:0]   LINE_MAX = '1;
  localparam logic [COLUMN_BITS-1:0] COL_MAX  = '1;
  localparam logic [LENGTH_BITS-1:0] LEN_MAX  = '1;

  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_QUOTE  = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_UNDER  = 8'h5F;

  mode_t                  mode_r, mode_nxt;
  logic [LINE_BITS-1:0]   line_r, line_nxt, tsl_r, tsl_nxt;
  logic [COLUMN_BITS-1:0] col_r, col_nxt, tsc_r, tsc_nxt, dotc_r, dotc_nxt;
  logic [OFFSET_BITS-1:0] off_r, off_nxt, tso_r, tso_nxt;
  logic [LENGTH_BITS-1:0] len_r, len_nxt;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
  endfunction

  function automatic logic [LENGTH_BITS-1:0] len_inc(input logic [LENGTH_BITS-1:0] v);
    return (v == LEN_MAX) ? v : v + 1'b1;
  endfunction

  function automatic cls_t classify(input logic [7:0] c);
    cls_t r;
    r = '{space: 1'b0, mode: M_IDLE, single: 1'b0, kind: K_INVALID};
    if ((c == " ") || ((c >= 8'd9) && (c <= 8'd13))) r.space = 1'b1;
    else if (is_alpha(c)) r.mode = M_IDENT;
    else if (is_digit(c)) r.mode = M_NUM_INT;
    else begin
      case (c)
        CH_QUOTE:  r.mode = M_CHAR_OPEN;
        CH_DQUOTE: r.mode = M_STR;
        "+": r.mode = M_PLUS;
        "-": r.mode = M_MINUS;
        "*": r.mode = M_STAR;
        "/": r.mode = M_SLASH;
        "%": r.mode = M_PERCENT;
        "=": r.mode = M_EQUAL;
        "!": r.mode = M_BANG;
        ">": r.mode = M_GT;
        "<": r.mode = M_LT;
        "&": r.mode = M_AMP;
        "|": r.mode = M_PIPE;
        "^": r.mode = M_CARET;
        ":": r.mode = M_COLON;
        "~": begin r.single = 1'b1; r.kind = K_TILDE;  end
        "@": begin r.single = 1'b1; r.kind = K_AT;     end
        CH_DOT: begin r.single = 1'b1; r.kind = K_DOT; end
        "?": begin r.single = 1'b1; r.kind = K_QUEST;  end
        ";": begin r.single = 1'b1; r.kind = K_SEMI;   end
        ",": begin r.single = 1'b1; r.kind = K_COMMA;  end
        "[": begin r.single = 1'b1; r.kind = K_LBRACK; end
        "]": begin r.single = 1'b1; r.kind = K_RBRACK; end
        "(": begin r.single = 1'b1; r.kind = K_LPAREN; end
        ")": begin r.single = 1'b1; r.kind = K_RPAREN; end
        "{": begin r.single = 1'b1; r.kind = K_LBRACE; end
        "}": begin r.single = 1'b1; r.kind = K_RBRACE; end
        default: r.single = 1'b0;
      endcase
    end
    return r;
  endfunction

  function automatic pair_t op_pair(input mode_t m, input logic [7:0] c);
    pair_t p;
    p = '{hit: 1'b0, kind: K_INVALID};
    case (m)
      M_PLUS:    if (c == "+") p = '{1'b1, K_INC};   else if (c == "=") p = '{1'b1, K_PLUS_EQ};
      M_MINUS: begin
        if (c == "-") p = '{1'b1, K_DEC};
        else if (c == "=") p = '{1'b1, K_MINUS_EQ};
        else if (c == ">") p = '{1'b1, K_ARROW};
      end
      M_STAR:    if (c == "=") p = '{1'b1, K_STAR_EQ};
      M_PERCENT: if (c == "=") p = '{1'b1, K_PCT_EQ};
      M_EQUAL:   if (c == "=") p = '{1'b1, K_EQ};
      M_BANG:    if (c == "=") p = '{1'b1, K_NE};
      M_GT:      if (c == "=") p = '{1'b1, K_GE};
      M_LT:      if (c == "=") p = '{1'b1, K_LE};
      M_AMP:     if (c == "&") p = '{1'b1, K_AND};   else if (c == "=") p = '{1'b1, K_AMP_EQ};
      M_PIPE:    if (c == "|") p = '{1'b1, K_OR};    else if (c == "=") p = '{1'b1, K_PIPE_EQ};
      M_CARET:   if (c == "=") p = '{1'b1, K_CARET_EQ};
      M_COLON:   if (c == ":") p = '{1'b1, K_SCOPE};
      default:   p.hit = 1'b0;
    endcase
    return p;
  endfunction

  function automatic kind_t op_alone(input mode_t m);
    case (m)
      M_PLUS:    return K_PLUS;
      M_MINUS:   return K_MINUS;
      M_STAR:    return K_STAR;
      M_SLASH:   return K_SLASH;
      M_PERCENT: return K_PCT;
      M_EQUAL:   return K_ASSIGN;
      M_BANG:    return K_BANG;
      M_GT:      return K_GT;
      M_GTGT:    return K_SHR;
      M_LT:      return K_LT;
      M_LTLT:    return K_SHL;
      M_AMP:     return K_AMP;
      M_PIPE:    return K_PIPE;
      M_CARET:   return K_CARET;
      default:   return K_COLON;
    endcase
  endfunction

  function automatic out_item_t mk(input kind_t k, input logic [LINE_BITS-1:0] ln,
                                   input logic [COLUMN_BITS-1:0] col,
                                   input logic [OFFSET_BITS-1:0] off,
                                   input logic [LENGTH_BITS-1:0] len, input err_t e);
    out_item_t r;
    r.token_kind   = k;
    r.tok_line     = ln;
    r.tok_column   = col;
    r.start_offset = off;
    r.token_length = len;
    r.error_code   = e;
    r.last_item    = 1'b0;
    return r;
  endfunction

  logic [7:0] c;
  logic       do_idle;
  cls_t       cls;
  pair_t      pr;
  logic [1:0] n;
  out_item_t [MAX_RES-1:0] res;
  logic [LENGTH_BITS-1:0]  g1;

  assign c   = in_item.char_code;
  assign cls = classify(c);
  assign pr  = op_pair(mode_r, c);
  assign g1  = len_inc(len_r);

  always_comb begin
    mode_nxt = mode_r;
    line_nxt = line_r;
    col_nxt  = col_r;
    off_nxt  = off_r;
    tsl_nxt  = tsl_r;
    tsc_nxt  = tsc_r;
    tso_nxt  = tso_r;
    len_nxt  = len_r;
    dotc_nxt = dotc_r;
    do_idle  = 1'b0;
    n        = 2'd0;
    res      = '0;

    if (in_item.end_of_source) begin
      case (mode_r)
        M_IDLE, M_LINE_CMT: n = 2'd0;
        M_IDENT: begin
          res[n] = mk(K_IDENT, tsl_r, tsc_r, tso_r, len_r, E_NONE); n = n + 2'd1;
        end
        M_NUM_INT, M_NUM_FRAC: begin
          res[n] = mk(K_NUMBER, tsl_r, tsc_r, tso_r, len_r, E_NONE); n = n + 2'd1;
        end
        M_NUM_DOT: begin
          res[n] = mk(K_NUMBER, tsl_r, tsc_r, tso_r, len_r, E_NONE); n = n + 2'd1;
          res[n] = mk(K_DOT, line_r, dotc_r, off_r - 1'b1, LENGTH_BITS'(1), E_NONE);
          n = n + 2'd1;
        end
        M_CHAR_OPEN, M_CHAR_ONE, M_CHAR_MULTI: begin
          res[n] = mk(K_INVALID, tsl_r, tsc_r, tso_r, len_r, E_OPEN_CHAR); n = n + 2'd1;
        end
        M_STR: begin
          res[n] = mk(K_INVALID, tsl_r, tsc_r, tso_r, len_r, E_OPEN_STR); n = n + 2'd1;
        end
        M_BLOCK, M_BLOCK_STAR: begin
          res[n] = mk(K_DIAG, tsl_r, tsc_r, tso_r, len_r, E_OPEN_CMT); n = n + 2'd1;
        end
        M_GTGT, M_LTLT: begin
          res[n] = mk(op_alone(mode_r), tsl_r, tsc_r, tso_r, LENGTH_BITS'(2), E_NONE);
          n = n + 2'd1;
        end
        default: begin
          res[n] = mk(op_alone(mode_r), tsl_r, tsc_r, tso_r, LENGTH_BITS'(1), E_NONE);
          n = n + 2'd1;
        end
      endcase
      res[n] = mk(K_END, line_r, col_r, off_r, '0, E_NONE);
      n = n + 2'd1;
      mode_nxt = M_IDLE;
      line_nxt = LINE_BITS'(1);
      col_nxt  = COLUMN_BITS'(1);
      off_nxt  = '0;
      tsl_nxt  = LINE_BITS'(1);
      tsc_nxt  = COLUMN_BITS'(1);
      tso_nxt  = '0;
      len_nxt  = '0;
      dotc_nxt = '0;
    end else begin
      case (mode_r)
        M_IDLE: do_idle = 1'b1;
        M_IDENT: begin
          if (is_alpha(c) || is_digit(c) || (c == CH_UNDER)) len_nxt = g1;
          else begin
            res[n] = mk(K_IDENT, tsl_r, tsc_r, tso_r, len_r, E_NONE); n = n + 2'd1;
            mode_nxt = M_IDLE;
            do_idle = 1'b1;
          end
        end
        M_NUM_INT: begin
          if (is_digit(c)) len_nxt = g1;
          else if (c == CH_DOT) begin
            dotc_nxt = col_r;
            mode_nxt = M_NUM_DOT;
          end else begin
            res[n] = mk(K_NUMBER, tsl_r, tsc_r, tso_r, len_r, E_NONE); n = n + 2'd1;
            mode_nxt = M_IDLE;
            do_idle = 1'b1;
          end
        end
        M_NUM_DOT: begin
          // The dot joins the number only when a digit follows it.
          if (is_digit(c)) begin
            len_nxt  = len_inc(g1);
            mode_nxt = M_NUM_FRAC;
          end else begin
            res[n] = mk(K_NUMBER, tsl_r, tsc_r, tso_r, len_r, E_NONE); n = n + 2'd1;
            res[n] = mk(K_DOT, line_r, dotc_r, off_r - 1'b1, LENGTH_BITS'(1), E_NONE);
            n = n + 2'd1;
            mode_nxt = M_IDLE;
            do_idle = 1'b1;
          end
        end
        M_NUM_FRAC: begin
          if (is_digit(c)) len_nxt = g1;
          else begin
            res[n] = mk(K_NUMBER, tsl_r, tsc_r, tso_r, len_r, E_NONE); n = n + 2'd1;
            mode_nxt = M_IDLE;
            do_idle = 1'b1;
          end
        end
        M_CHAR_OPEN, M_CHAR_ONE: begin
          len_nxt = g1;
          if (c == CH_QUOTE) begin
            res[n] = mk(K_CHAR, tsl_r, tsc_r, tso_r, g1, E_NONE); n = n + 2'd1;
            mode_nxt = M_IDLE;
          end else mode_nxt = (mode_r == M_CHAR_OPEN) ? M_CHAR_ONE : M_CHAR_MULTI;
        end
        M_CHAR_MULTI: begin
          len_nxt = g1;
          if (c == CH_QUOTE) begin
            res[n] = mk(K_INVALID, tsl_r, tsc_r, tso_r, g1, E_MULTI_CHAR); n = n + 2'd1;
            mode_nxt = M_IDLE;
          end
        end
        M_STR: begin
          len_nxt = g1;
          if (c == CH_DQUOTE) begin
            res[n] = mk(K_STRING, tsl_r, tsc_r, tso_r, g1, E_NONE); n = n + 2'd1;
            mode_nxt = M_IDLE;
          end
        end
        M_LINE_CMT: if (c == CH_LF) mode_nxt = M_IDLE;
        M_BLOCK, M_BLOCK_STAR: begin
          len_nxt = g1;
          if ((mode_r == M_BLOCK_STAR) && (c == "/")) mode_nxt = M_IDLE;
          else mode_nxt = (c == "*") ? M_BLOCK_STAR : M_BLOCK;
        end
        M_SLASH: begin
          if (c == "/") mode_nxt = M_LINE_CMT;
          else if (c == "*") begin
            len_nxt  = LENGTH_BITS'(2);
            mode_nxt = M_BLOCK;
          end else if (c == "=") begin
            res[n] = mk(K_SLASH_EQ, tsl_r, tsc_r, tso_r, LENGTH_BITS'(2), E_NONE);
            n = n + 2'd1;
            mode_nxt = M_IDLE;
          end else begin
            res[n] = mk(K_SLASH, tsl_r, tsc_r, tso_r, LENGTH_BITS'(1), E_NONE);
            n = n + 2'd1;
            mode_nxt = M_IDLE;
            do_idle = 1'b1;
          end
        end
        M_GTGT, M_LTLT: begin
          if (c == "=") begin
            res[n] = mk((mode_r == M_GTGT) ? K_SHR_EQ : K_SHL_EQ, tsl_r, tsc_r, tso_r,
                        LENGTH_BITS'(3), E_NONE);
            n = n + 2'd1;
            mode_nxt = M_IDLE;
          end else begin
            res[n] = mk(op_alone(mode_r), tsl_r, tsc_r, tso_r, LENGTH_BITS'(2), E_NONE);
            n = n + 2'd1;
            mode_nxt = M_IDLE;
            do_idle = 1'b1;
          end
        end
        default: begin
          if ((mode_r == M_GT) && (c == ">")) mode_nxt = M_GTGT;
          else if ((mode_r == M_LT) && (c == "<")) mode_nxt = M_LTLT;
          else if (pr.hit) begin
            res[n] = mk(pr.kind, tsl_r, tsc_r, tso_r, LENGTH_BITS'(2), E_NONE);
            n = n + 2'd1;
            mode_nxt = M_IDLE;
          end else begin
            res[n] = mk(op_alone(mode_r), tsl_r, tsc_r, tso_r, LENGTH_BITS'(1), E_NONE);
            n = n + 2'd1;
            mode_nxt = M_IDLE;
            do_idle = 1'b1;
          end
        end
      endcase

      // The current byte opens a new token, or stands alone as one.
      if (do_idle && !cls.space) begin
        tsl_nxt  = line_r;
        tsc_nxt  = col_r;
        tso_nxt  = off_r;
        len_nxt  = LENGTH_BITS'(1);
        mode_nxt = cls.mode;
        if (cls.mode == M_IDLE) begin
          res[n] = mk(cls.single ? cls.kind : K_INVALID, line_r, col_r, off_r,
                      LENGTH_BITS'(1), cls.single ? E_NONE : E_BAD_CHAR);
          n = n + 2'd1;
        end
      end

      if (c == CH_LF) begin
        line_nxt = (line_r == LINE_MAX) ? line_r : line_r + 1'b1;
        col_nxt  = COLUMN_BITS'(1);
      end else col_nxt = (col_r == COL_MAX) ? col_r : col_r + 1'b1;
      off_nxt = off_r + 1'b1;
    end
  end

  assign bundle_valid = accept && (n != 2'd0);
  assign bundle.cnt   = n;
  assign bundle.res   = res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_IDLE;
      line_r <= LINE_BITS'(1);
      col_r  <= COLUMN_BITS'(1);
      off_r  <= '0;
      tsl_r  <= LINE_BITS'(1);
      tsc_r  <= COLUMN_BITS'(1);
      tso_r  <= '0;
      len_r  <= '0;
      dotc_r <= '0;
    end else if (accept) begin
      mode_r <= mode_nxt;
      line_r <= line_nxt;
      col_r  <= col_nxt;
      off_r  <= off_nxt;
      tsl_r  <= tsl_nxt;
      tsc_r  <= tsc_nxt;
      tso_r  <= tso_nxt;
      len_r  <= len_nxt;
      dotc_r <= dotc_nxt;
    end
  end

endmodule

[sv/cts_queue.sv]
module cts_queue import cts_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    wr_en,
  input  bundle_t wr_data,
  input  logic    rd_en,
  output bundle_t rd_data,
  output logic    full,
  output logic    empty
);

  `include "c_like_token_scanner_assert.svh"

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  bundle_t [DEPTH-1:0] mem_r;
  logic [PW-1:0] wp_r, rp_r;
  logic [CW-1:0] cnt_r;
  logic          do_wr, do_rd;

  assign full    = (cnt_r == FULL_CNT);
  assign empty   = (cnt_r == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (do_wr) mem_r[wp_r] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_wr) wp_r <= (wp_r == LAST_PTR) ? '0 : wp_r + 1'b1;
      if (do_rd) rp_r <= (rp_r == LAST_PTR) ? '0 : rp_r + 1'b1;
      if (do_wr && !do_rd) cnt_r <= cnt_r + 1'b1;
      else if (do_rd && !do_wr) cnt_r <= cnt_r - 1'b1;
    end
  end

  `CTS_NEVER(a_cnt_bound, cnt_r > FULL_CNT)
  `CTS_NEVER(a_no_write_when_full, wr_en && full)
  `CTS_ASSERT(a_cnt_tracks, (do_wr && !do_rd) |=> (cnt_r == $past(cnt_r) + 1'b1))
  `CTS_NEVER(a_bundle_nonempty, do_wr && (wr_data.cnt == 2'd0))

endmodule

[sv/cts_back.sv]
module cts_back import cts_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  bundle_t   head,
  input  logic      q_empty,
  output logic      q_pop,
  output logic      out_empty,
  input  logic      out_pop,
  output out_item_t out_item
);

  logic       valid_r;
  out_item_t  data_r;
  out_item_t  data_nxt;
  logic [1:0] idx_r;
  logic       load, last;

  assign load      = !valid_r || out_pop;
  assign last      = (idx_r == (head.cnt - 2'd1));
  assign q_pop     = load && !q_empty && last;
  assign out_empty = !valid_r;
  assign out_item  = data_r;

  always_comb begin
    data_nxt           = head.res[idx_r];
    data_nxt.last_item = last;
  end

  always_ff @(posedge clk) begin
    if (load && !q_empty) data_r <= data_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= '0;
    end else if (load) begin
      valid_r <= !q_empty;
      if (!q_empty) idx_r <= last ? 2'd0 : idx_r + 2'd1;
    end
  end

endmodule
